// ===== hdl/drod_pkg.sv =====
package drod_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned DepthBits = 16;

  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned RowW     = $clog2(MaxHeight);
  localparam int unsigned FwW      = 11;
  localparam int unsigned RoiPosW  = 10;
  localparam int unsigned RoiLenW  = 11;
  localparam int unsigned DepthW   = 16;
  localparam int unsigned HitW     = 21;
  localparam int unsigned SumW     = 37;
  localparam int unsigned QuotW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 21;

  localparam logic [HitW-1:0] HitMax = {HitW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth = 3'd0,
    RegRoiLeft    = 3'd1,
    RegRoiTop     = 3'd2,
    RegRoiWidth   = 3'd3,
    RegRoiHeight  = 3'd4,
    RegNearLimit  = 3'd5,
    RegFarLimit   = 3'd6,
    RegMinHits    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [FwW-1:0]     frame_width;
    logic [RoiPosW-1:0] roi_left;
    logic [RoiPosW-1:0] roi_top;
    logic [RoiLenW-1:0] roi_width;
    logic [RoiLenW-1:0] roi_height;
    logic [DepthW-1:0]  near_limit;
    logic [DepthW-1:0]  far_limit;
    logic [HitW-1:0]    min_hits;
  } cfg_t;

  typedef struct packed {
    logic [HitW-1:0] hits;
    logic [SumW-1:0] sum;
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== hdl/drod_front.sv =====
module drod_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  drod_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [15:0]           depth_i,
  input  logic                  last_of_frame_i,
  input  drod_pkg::q_status_t   q_status_i,
  output logic                  push_o,
  output drod_pkg::frame_t      push_data_o
);
  import drod_pkg::*;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [HitW-1:0] hit_q, hit_d;
  logic [SumW-1:0] sum_q, sum_d;

  logic              accept;
  logic [FwW-1:0]    eff_w;
  logic [DepthW-1:0] d_val;
  logic              col_in, row_in, hit;
  logic [RoiLenW:0]  col_end, row_end;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign d_val      = DepthW'(depth_i[DepthBits-1:0]);

  always_comb begin
    eff_w = cfg_i.frame_width;
    if (cfg_i.frame_width == '0) begin
      eff_w = FwW'(1);
    end else if (cfg_i.frame_width > FwW'(MaxWidth)) begin
      eff_w = FwW'(MaxWidth);
    end
  end

  assign col_end = (RoiLenW+1)'(cfg_i.roi_left) + (RoiLenW+1)'(cfg_i.roi_width);
  assign row_end = (RoiLenW+1)'(cfg_i.roi_top) + (RoiLenW+1)'(cfg_i.roi_height);
  assign col_in  = ((RoiLenW+1)'(col_q) >= (RoiLenW+1)'(cfg_i.roi_left)) &&
                   ((RoiLenW+1)'(col_q) < col_end);
  assign row_in  = ((RoiLenW+1)'(row_q) >= (RoiLenW+1)'(cfg_i.roi_top)) &&
                   ((RoiLenW+1)'(row_q) < row_end);
  assign hit     = col_in && row_in && (d_val > cfg_i.near_limit) &&
                   (d_val < cfg_i.far_limit) && (hit_q != HitMax);

  always_comb begin
    hit_d = hit_q;
    sum_d = sum_q;
    col_d = col_q;
    row_d = row_q;
    if (hit) begin
      hit_d = hit_q + HitW'(1);
      sum_d = sum_q + SumW'(d_val);
    end
    push_data_o.hits = hit_d;
    push_data_o.sum  = sum_d;
    if (last_of_frame_i) begin
      hit_d = '0;
      sum_d = '0;
      col_d = '0;
      row_d = '0;
    end else if ((FwW'(col_q) + FwW'(1)) >= eff_w) begin
      col_d = '0;
      if (row_q < RowW'(MaxHeight - 1)) begin
        row_d = row_q + RowW'(1);
      end
    end else begin
      col_d = col_q + ColW'(1);
    end
  end

  assign push_o = accept & last_of_frame_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      hit_q <= '0;
      sum_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      hit_q <= hit_d;
      sum_q <= sum_d;
    end
  end

endmodule

// ===== hdl/drod_queue.sv =====
module drod_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  drod_pkg::frame_t     push_data_i,
  input  logic                 pop_i,
  output drod_pkg::frame_t     pop_data_o,
  output drod_pkg::q_status_t  status_o
);
  import drod_pkg::*;

  frame_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign status_o.empty = (count_q == 2'd0);
  assign status_o.full  = (count_q == 2'd2);
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hdl/drod_back.sv =====
module drod_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [drod_pkg::HitW-1:0]          min_hits_i,
  input  drod_pkg::q_status_t                q_status_i,
  input  drod_pkg::frame_t                   pop_data_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               obstacle_o,
  output logic [15:0]                        average_depth_o,
  output logic [20:0]                        hit_count_o
);
  import drod_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StHold
  } state_e;

  localparam int unsigned CntW = $clog2(QuotW);

  state_e           state_q;
  logic [SumW-1:0]  rem_q;
  logic [SumW-1:0]  dvs_q;
  logic [QuotW-1:0] quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             obst_q;
  logic [HitW-1:0]  hits_q;
  logic             ge;
  logic             obst_new;

  assign pop_o    = (state_q == StIdle) & ~q_status_i.empty;
  assign ge       = rem_q >= dvs_q;
  assign obst_new = pop_data_i.hits > min_hits_i;

  // restoring division, quotient fits QuotW bits since each depth does
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      obst_q  <= 1'b0;
      hits_q  <= '0;
      quot_q  <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (!q_status_i.empty) begin
            hits_q <= pop_data_i.hits;
            obst_q <= obst_new;
            rem_q  <= pop_data_i.sum;
            dvs_q  <= SumW'(pop_data_i.hits) << (QuotW - 1);
            quot_q <= '0;
            cnt_q  <= CntW'(QuotW - 1);
            state_q <= obst_new ? StDiv : StHold;
          end
        end
        StDiv: begin
          if (ge) begin
            rem_q <= rem_q - dvs_q;
          end
          quot_q <= {quot_q[QuotW-2:0], ge};
          dvs_q  <= dvs_q >> 1;
          cnt_q  <= cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            state_q <= StHold;
          end
        end
        StHold: begin
          if (!out_stall_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o     = (state_q == StHold);
  assign obstacle_o      = obst_q;
  assign average_depth_o = quot_q;
  assign hit_count_o     = hits_q;

endmodule

// ===== hdl/depth_roi_obstacle_detect.sv =====
// Counts depth pixels that fall strictly between near_limit and far_limit inside a
// rectangular window of a raster frame and reports, once per frame ended by the beat marked
// last_of_frame, an obstacle flag (hit count above min_hits), the floor of the mean hit
// depth (zero when no obstacle) and the hit count. Pixels are taken one per clock; the
// per-frame average is computed by a restoring divider in the back end while the next
// frame streams in, and a two-entry frame queue lets up to two finished frames wait for
// it. The input stalls only while that queue is full. Configuration writes must be made
// while the block is idle.
module depth_roi_obstacle_detect (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [20:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] depth_i,
  input  logic        last_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        obstacle_o,
  output logic [15:0] average_depth_o,
  output logic [20:0] hit_count_o
);
  import drod_pkg::*;

  cfg_t      cfg_q;
  q_status_t q_status;
  frame_t    push_data, pop_data;
  logic      push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width <= FwW'(640);
      cfg_q.roi_left    <= RoiPosW'(160);
      cfg_q.roi_top     <= RoiPosW'(160);
      cfg_q.roi_width   <= RoiLenW'(320);
      cfg_q.roi_height  <= RoiLenW'(160);
      cfg_q.near_limit  <= DepthW'(100);
      cfg_q.far_limit   <= DepthW'(1200);
      cfg_q.min_hits    <= HitW'(50);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegFrameWidth: cfg_q.frame_width <= cfg_data_i[FwW-1:0];
        RegRoiLeft:    cfg_q.roi_left    <= cfg_data_i[RoiPosW-1:0];
        RegRoiTop:     cfg_q.roi_top     <= cfg_data_i[RoiPosW-1:0];
        RegRoiWidth:   cfg_q.roi_width   <= cfg_data_i[RoiLenW-1:0];
        RegRoiHeight:  cfg_q.roi_height  <= cfg_data_i[RoiLenW-1:0];
        RegNearLimit:  cfg_q.near_limit  <= cfg_data_i[DepthW-1:0];
        RegFarLimit:   cfg_q.far_limit   <= cfg_data_i[DepthW-1:0];
        RegMinHits:    cfg_q.min_hits    <= cfg_data_i[HitW-1:0];
        default:       cfg_q             <= cfg_q;
      endcase
    end
  end

  drod_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i           (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .depth_i,
    .last_of_frame_i,
    .q_status_i      (q_status),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  drod_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  drod_back u_back (
    .clk_i,
    .rst_ni,
    .min_hits_i      (cfg_q.min_hits),
    .q_status_i      (q_status),
    .pop_data_i      (pop_data),
    .pop_o           (pop),
    .out_valid_o,
    .out_stall_i,
    .obstacle_o,
    .average_depth_o,
    .hit_count_o
  );

endmodule

// ===== verif/tb_depth_roi_obstacle_detect.sv =====
module tb_depth_roi_obstacle_detect;
  import drod_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned ItemTarget    = 1950;
  localparam int unsigned FrameTarget   = 60;

  typedef struct packed {
    logic              obstacle;
    logic [DepthW-1:0] average_depth;
    logic [HitW-1:0]   hit_count;
  } frame_report_t;

  class obstacle_scoreboard;
    cfg_t            regs;
    int unsigned     column;
    int unsigned     row;
    logic [HitW-1:0] hit_acc;
    logic [SumW-1:0] sum_acc;
    frame_report_t   pending_frames[$];
    int unsigned     mismatches;

    function new();
      regs.frame_width = 640;
      regs.roi_left    = 160;
      regs.roi_top     = 160;
      regs.roi_width   = 320;
      regs.roi_height  = 160;
      regs.near_limit  = 100;
      regs.far_limit   = 1200;
      regs.min_hits    = 50;
      column     = 0;
      row        = 0;
      hit_acc    = '0;
      sum_acc    = '0;
      mismatches = 0;
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      $display("%s", msg);
    endtask

    function void apply_write(input reg_idx_e idx, input logic [CfgDataW-1:0] data);
      case (idx)
        RegFrameWidth: regs.frame_width = data[FwW-1:0];
        RegRoiLeft:    regs.roi_left    = data[RoiPosW-1:0];
        RegRoiTop:     regs.roi_top     = data[RoiPosW-1:0];
        RegRoiWidth:   regs.roi_width   = data[RoiLenW-1:0];
        RegRoiHeight:  regs.roi_height  = data[RoiLenW-1:0];
        RegNearLimit:  regs.near_limit  = data[DepthW-1:0];
        RegFarLimit:   regs.far_limit   = data[DepthW-1:0];
        RegMinHits:    regs.min_hits    = data[HitW-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(input logic [DepthW-1:0] depth, input logic last);
      int unsigned   eff_w;
      logic [SumW-1:0] quot;
      frame_report_t rep;
      eff_w = regs.frame_width;
      if (eff_w == 0) eff_w = 1;
      if (eff_w > MaxWidth) eff_w = MaxWidth;
      if (column >= regs.roi_left && column < regs.roi_left + regs.roi_width &&
          row >= regs.roi_top && row < regs.roi_top + regs.roi_height &&
          depth > regs.near_limit && depth < regs.far_limit && hit_acc != HitMax) begin
        hit_acc++;
        sum_acc += depth;
      end
      if (last) begin
        rep.obstacle      = hit_acc > regs.min_hits;
        rep.average_depth = '0;
        if (rep.obstacle) begin
          quot = sum_acc / hit_acc;
          rep.average_depth = (quot > 65535) ? 16'hFFFF : quot[DepthW-1:0];
        end
        rep.hit_count = hit_acc;
        pending_frames.push_back(rep);
        column  = 0;
        row     = 0;
        hit_acc = '0;
        sum_acc = '0;
      end else if (column + 1 >= eff_w) begin
        column = 0;
        if (row < MaxHeight - 1) row++;
      end else begin
        column++;
      end
    endfunction

    task check_result(input logic obstacle, input logic [DepthW-1:0] average_depth,
                      input logic [HitW-1:0] hit_count);
      frame_report_t want;
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat: obstacle %0d avg %0d hits %0d",
                                  obstacle, average_depth, hit_count));
      end else begin
        want = pending_frames.pop_front();
        if (obstacle !== want.obstacle)
          report_mismatch($sformatf("obstacle: got %0d expected %0d",
                                    obstacle, want.obstacle));
        if (average_depth !== want.average_depth)
          report_mismatch($sformatf("average_depth: got %0d expected %0d",
                                    average_depth, want.average_depth));
        if (hit_count !== want.hit_count)
          report_mismatch($sformatf("hit_count: got %0d expected %0d",
                                    hit_count, want.hit_count));
      end
    endtask

    task flush_leftovers();
      while (pending_frames.size() != 0) begin
        void'(pending_frames.pop_front());
        report_mismatch("expected result beat never arrived");
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [DepthW-1:0]   depth_i;
  logic                last_of_frame_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                obstacle_o;
  logic [DepthW-1:0]   average_depth_o;
  logic [HitW-1:0]     hit_count_o;

  obstacle_scoreboard sb;
  int unsigned        pixels_sent;
  int unsigned        frames_seen;
  int unsigned        quiet_cycles;
  int unsigned        stall_hold;
  int unsigned        near_v;
  int unsigned        far_v;
  bit                 calm;

  depth_roi_obstacle_detect DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [DepthW-1:0] next_depth();
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    r  = $urandom_range(0, 99);
    lo = (near_v > 2) ? near_v - 2 : 0;
    hi = (far_v + 2 > 65535) ? 65535 : far_v + 2;
    if (r < 60) return DepthW'($urandom_range(lo, hi));
    if (r < 75) return DepthW'($urandom_range(0, 1) ? near_v : far_v);
    return DepthW'($urandom);
  endfunction

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (stall_hold > 0) stall_hold--;
    else if ($urandom_range(0, 3) == 0) stall_hold = idle_len();
    out_stall_i <= (stall_hold != 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.apply_write(reg_idx_e'(cfg_idx_i), cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_pixel(depth_i, last_of_frame_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(obstacle_o, average_depth_o, hit_count_o);
        frames_seen++;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  task automatic push_pixel(input logic [DepthW-1:0] depth, input logic last);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    depth_i         <= depth;
    last_of_frame_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
  endtask

  task automatic send_frame(input logic [DepthW-1:0] px[$]);
    foreach (px[i]) push_pixel(px[i], i == px.size() - 1);
  endtask

  task automatic send_random_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_pixel(next_depth(), i == len - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    int unsigned w;
    case (idx)
      RegFrameWidth, RegRoiWidth, RegRoiHeight: w = RoiLenW;
      RegRoiLeft, RegRoiTop:                    w = RoiPosW;
      RegNearLimit, RegFarLimit:                w = DepthW;
      default:                                  w = HitW;
    endcase
    @(negedge clk_i);
    cfg_we_i  <= 1'b1;
    cfg_idx_i <= idx;
    // junk above the register width must be dropped
    if ($urandom_range(0, 1))
      cfg_data_i <= CfgDataW'((longint'($urandom) << w) | value);
    else
      cfg_data_i <= CfgDataW'(value);
  endtask

  task automatic program_regs(input int unsigned fw, input int unsigned lf,
                              input int unsigned tp, input int unsigned wd,
                              input int unsigned ht, input int unsigned nr,
                              input int unsigned fr, input int unsigned mh);
    write_reg(RegFrameWidth, fw);
    write_reg(RegRoiLeft, lf);
    write_reg(RegRoiTop, tp);
    write_reg(RegRoiWidth, wd);
    write_reg(RegRoiHeight, ht);
    write_reg(RegNearLimit, nr);
    write_reg(RegFarLimit, fr);
    write_reg(RegMinHits, mh);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    near_v = nr;
    far_v  = fr;
  endtask

  task automatic program_random();
    int unsigned r;
    int unsigned fw, ew, span, lf, tp, wd, ht, nr, fr, mh;
    r = $urandom_range(0, 19);
    if (r < 14) fw = $urandom_range(1, 12);
    else if (r < 16) fw = 0;
    else if (r < 18) fw = 1024;
    else fw = 2047;
    ew   = (fw == 0) ? 1 : (fw > 1024) ? 1024 : fw;
    span = (ew > 16) ? 16 : ew;
    lf = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, span);
    tp = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 5);
    case ($urandom_range(0, 9))
      0:       wd = 0;
      1:       wd = 1024;
      2:       wd = 2047;
      default: wd = $urandom_range(1, span + 1);
    endcase
    case ($urandom_range(0, 9))
      0:       ht = 0;
      1:       ht = 1024;
      default: ht = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 9))
      0:       nr = 0;
      1:       nr = 65535;
      default: nr = $urandom_range(0, 3000);
    endcase
    case ($urandom_range(0, 9))
      0:       fr = 65535;
      1:       fr = 0;
      2:       fr = $urandom_range(0, nr);
      default: fr = (nr + 3000 > 65535) ? 65535 : nr + $urandom_range(1, 3000);
    endcase
    mh = ($urandom_range(0, 9) == 0) ? HitMax : $urandom_range(0, 5);
    program_regs(fw, lf, tp, wd, ht, nr, fr, mh);
  endtask

  initial begin
    logic [DepthW-1:0] px[$];
    int unsigned       nframes;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = RegFrameWidth;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    depth_i         = '0;
    last_of_frame_i = 1'b0;
    out_stall_i     = 1'b0;
    stall_hold      = 0;
    pixels_sent     = 0;
    frames_seen     = 0;
    quiet_cycles    = 0;
    near_v          = 100;
    far_v           = 1200;
    calm            = 1'b1;
    sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset window lies far below a tiny frame
    px = '{16'd500, 16'd600, 16'd700};
    send_frame(px);
    wait_drained();

    // 2x2 window, limits exclusive on both ends
    calm = 1'b0;
    program_regs(4, 1, 1, 2, 2, 100, 1200, 0);
    px = '{16'd0, 16'hFFFF, 16'd100, 16'd101, 16'd500, 16'd101, 16'd1199, 16'd1200,
           16'd7, 16'd100, 16'd1200, 16'd3};
    send_frame(px);
    wait_drained();

    // zero frame width, widest limits, min hits at max
    program_regs(0, 0, 0, 1024, 1024, 0, 65535, HitMax);
    px = '{16'hFFFF, 16'd0, 16'd1, 16'hFFFE};
    send_frame(px);
    wait_drained();

    // near above far, oversized width, window past the edge
    program_regs(2047, 1023, 1023, 2047, 2047, 65535, 0, 0);
    px = '{16'd1000, 16'd2000};
    send_frame(px);
    wait_drained();

    // single-pixel frame is counted before the result
    program_regs(7, 0, 0, 1, 1, 0, 65535, 0);
    px = '{16'd4321};
    send_frame(px);
    wait_drained();

    // row saturation: one-pixel rows running past the last row
    program_regs(0, 0, 1020, 1, 4, 0, 65535, 3);
    send_random_frame(1030);
    wait_drained();

    while (pixels_sent < ItemTarget || frames_seen < FrameTarget) begin
      calm = ($urandom_range(0, 4) == 0);
      program_random();
      nframes = $urandom_range(1, 5);
      for (int unsigned f = 0; f < nframes; f++) begin
        send_random_frame($urandom_range(1, 30));
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
      wait_drained();
    end

    sb.flush_leftovers();
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/drod_pkg.sv
hdl/drod_front.sv
hdl/drod_queue.sv
hdl/drod_back.sv
hdl/depth_roi_obstacle_detect.sv
verif/tb_depth_roi_obstacle_detect.sv
